// File: design/nec_enc_pkg.sv
package nec_enc_pkg;

  // field widths
  localparam int unsigned ByteW  = 8;
  localparam int unsigned MarkW  = 14;
  localparam int unsigned SpaceW = 17;
  localparam int unsigned CountW = 9;

  // default buffer length of the timing buffer the frame is sized against
  localparam int unsigned BUFFER_LEN_DEF = 128;

  // frame timing in microseconds
  localparam logic [MarkW-1:0]  MarkLead   = MarkW'(9000);
  localparam logic [MarkW-1:0]  MarkShort  = MarkW'(560);
  localparam logic [SpaceW-1:0] SpaceLead  = SpaceW'(4500);
  localparam logic [SpaceW-1:0] SpaceOne   = SpaceW'(1690);
  localparam logic [SpaceW-1:0] SpaceZero  = SpaceW'(560);
  localparam logic [SpaceW-1:0] SpaceRep   = SpaceW'(2250);
  localparam logic [SpaceW-1:0] SpaceRepGap = SpaceW'(98190);
  // per-bit time taken off the gap budget (mark plus space)
  localparam logic [SpaceW-1:0] BitOneTime  = SpaceW'(2250);
  localparam logic [SpaceW-1:0] BitZeroTime = SpaceW'(1120);
  // frame period less leader and stop mark: 110000 - 13500 - 560
  localparam logic [SpaceW-1:0] GapInit = SpaceW'(95940);
  // durations in the main frame
  localparam int unsigned MainDurations = 68;

  // program step codes
  localparam int unsigned PcW = 3;
  localparam logic [PcW-1:0] StepLead    = 3'd0;
  localparam logic [PcW-1:0] StepBit     = 3'd1;
  localparam logic [PcW-1:0] StepStop    = 3'd2;
  localparam logic [PcW-1:0] StepRepLead = 3'd3;
  localparam logic [PcW-1:0] StepRepTail = 3'd4;
  localparam logic [PcW-1:0] StepErr     = 3'd5;

  typedef enum logic [1:0] {
    MK_NONE,
    MK_LEAD,
    MK_SHORT
  } mark_sel_e;

  typedef enum logic [2:0] {
    SP_NONE,
    SP_LEAD,
    SP_BIT,
    SP_GAP,
    SP_REP,
    SP_REP_GAP
  } space_sel_e;

  // sequencing of the next step
  typedef enum logic [2:0] {
    NX_NEXT,      // fall through
    NX_END,       // item finished
    NX_BIT_LOOP,  // back to target until all 32 bits are out
    NX_REP_CHK,   // finish when no repeats requested
    NX_REP_LOOP   // back to target until the last repeat is out
  } nxt_sel_e;

  typedef struct packed {
    mark_sel_e      mark_sel;
    space_sel_e     space_sel;
    logic           status;
    logic           shift;
    logic           dec_rep;
    nxt_sel_e       nxt;
    logic [PcW-1:0] target;
  } ctrl_word_t;

  // control store
  function automatic ctrl_word_t nec_enc_ucode(input logic [PcW-1:0] pc);
    ctrl_word_t cw;
    cw = '{mark_sel: MK_NONE, space_sel: SP_NONE, status: 1'b0, shift: 1'b0,
           dec_rep: 1'b0, nxt: NX_END, target: StepLead};
    case (pc)
      StepLead: begin
        cw.mark_sel  = MK_LEAD;
        cw.space_sel = SP_LEAD;
        cw.nxt       = NX_NEXT;
      end
      StepBit: begin
        cw.mark_sel  = MK_SHORT;
        cw.space_sel = SP_BIT;
        cw.shift     = 1'b1;
        cw.nxt       = NX_BIT_LOOP;
        cw.target    = StepBit;
      end
      StepStop: begin
        cw.mark_sel  = MK_SHORT;
        cw.space_sel = SP_GAP;
        cw.nxt       = NX_REP_CHK;
      end
      StepRepLead: begin
        cw.mark_sel  = MK_LEAD;
        cw.space_sel = SP_REP;
        cw.nxt       = NX_NEXT;
      end
      StepRepTail: begin
        cw.mark_sel  = MK_SHORT;
        cw.space_sel = SP_REP_GAP;
        cw.dec_rep   = 1'b1;
        cw.nxt       = NX_REP_LOOP;
        cw.target    = StepRepLead;
      end
      StepErr: begin
        cw.status = 1'b1;
        cw.nxt    = NX_END;
      end
      default: begin
        cw.status = 1'b1;
        cw.nxt    = NX_END;
      end
    endcase
    return cw;
  endfunction

endpackage

// File: design/nec_enc_if.sv
// request channel: one frame to send
interface nec_enc_req_if;
  import nec_enc_pkg::*;
  logic              valid;
  logic              ready;
  logic [ByteW-1:0]  address;
  logic [ByteW-1:0]  command;
  logic [ByteW-1:0]  repeat_count;

  modport source (output valid, address, command, repeat_count, input ready);
  modport sink   (input valid, address, command, repeat_count, output ready);
endinterface

// result channel: the mark/space pairs of each request, one pair per transfer
interface nec_enc_rsp_if;
  import nec_enc_pkg::*;
  logic              valid;
  logic              ready;
  logic [MarkW-1:0]  mark_us;
  logic [SpaceW-1:0] space_us;
  logic              last;
  logic              status;
  logic [CountW-1:0] duration_count;

  modport source (output valid, mark_us, space_us, last, status, duration_count,
                  input ready);
  modport sink   (input valid, mark_us, space_us, last, status, duration_count,
                  output ready);
endinterface

// File: design/nec_ir_frame_encoder_top.sv
// NEC infrared frame encoder
//
// req_i takes one request (address, command, repeat_count) when valid and
// ready are both high; ready is high only while no frame is being produced.
// rsp_o then delivers the frame as mark/space pairs in microseconds: leader,
// 32 data bits LSB first (address, ~address, command, ~command), stop mark
// with the rest of the 110 ms period, then two pairs per repeat. The final
// pair carries last and the total duration count. A repeat count beyond what
// the buffer holds gives one pair with status set and nothing else.
// A small program in a control store steps the datapath: one pair leaves the
// sequencer per cycle into the output register while rsp_o does not stall, so
// a frame is 34 + 2 * repeat_count pairs (one pair for an error). A taken
// request is first registered in the sequencer, then its first pair goes through the output register.
// When rsp_o stalls the sequencer holds its step; nothing is dropped.
// Reset clears the sequencer and the output valid flag; the block comes out of
// reset ready for a request.
module nec_ir_frame_encoder_top #(
  parameter int unsigned BUFFER_LEN = nec_enc_pkg::BUFFER_LEN_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  nec_enc_req_if.sink       req_i,
  nec_enc_rsp_if.source     rsp_o
);
  import nec_enc_pkg::*;

  // repeats that fit behind the main frame
  localparam int unsigned AllowedRaw =
      (BUFFER_LEN <= MainDurations + 4) ? 0 : (BUFFER_LEN - MainDurations - 4 + 3) / 4;
  localparam int unsigned AllowedReps = (AllowedRaw > 255) ? 255 : AllowedRaw;

  logic                 busy_q;
  logic [PcW-1:0]       pc_q, pc_d;
  logic [4*ByteW-1:0]   bits_q;
  logic [4:0]           bit_cnt_q;
  logic [ByteW-1:0]     reps_q;
  logic [SpaceW-1:0]    gap_q;
  logic [CountW-1:0]    count_q;

  logic                 rsp_valid_q;
  logic [MarkW-1:0]     mark_q;
  logic [SpaceW-1:0]    space_q;
  logic                 last_q;
  logic                 status_q;
  logic [CountW-1:0]    dcnt_q;

  ctrl_word_t           cw;
  logic                 accept;
  logic                 fire;
  logic                 done;
  logic                 rep_err;
  logic [MarkW-1:0]     mark_val;
  logic [SpaceW-1:0]    space_val;

  assign req_i.ready = !busy_q;
  assign accept      = req_i.valid && !busy_q;
  assign rep_err     = (CountW'(req_i.repeat_count) > CountW'(AllowedReps));

  // control word of the current step
  assign cw   = nec_enc_ucode(pc_q);
  assign fire = busy_q && (!rsp_valid_q || rsp_o.ready);

  // next step selection
  always_comb begin
    pc_d = pc_q + 3'd1;
    done = 1'b0;
    case (cw.nxt)
      NX_NEXT: done = 1'b0;
      NX_END:  done = 1'b1;
      NX_BIT_LOOP: begin
        if (bit_cnt_q != 5'd31) pc_d = cw.target;
      end
      NX_REP_CHK: done = (reps_q == '0);
      NX_REP_LOOP: begin
        if (reps_q != 8'd1) pc_d = cw.target;
        else done = 1'b1;
      end
      default: done = 1'b1;
    endcase
  end

  // mark and space selection
  always_comb begin
    case (cw.mark_sel)
      MK_LEAD:  mark_val = MarkLead;
      MK_SHORT: mark_val = MarkShort;
      default:  mark_val = '0;
    endcase
    case (cw.space_sel)
      SP_LEAD:    space_val = SpaceLead;
      SP_BIT:     space_val = bits_q[0] ? SpaceOne : SpaceZero;
      SP_GAP:     space_val = gap_q;
      SP_REP:     space_val = SpaceRep;
      SP_REP_GAP: space_val = SpaceRepGap;
      default:    space_val = '0;
    endcase
  end

  // sequencer control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      pc_q   <= StepLead;
    end else if (accept) begin
      busy_q <= 1'b1;
      pc_q   <= rep_err ? StepErr : StepLead;
    end else if (fire) begin
      if (done) busy_q <= 1'b0;
      pc_q <= pc_d;
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    if (accept) begin
      bits_q    <= {~req_i.command, req_i.command, ~req_i.address, req_i.address};
      bit_cnt_q <= '0;
      reps_q    <= req_i.repeat_count;
      gap_q     <= GapInit;
      count_q   <= CountW'(MainDurations) + {req_i.repeat_count[6:0], 2'b00};
    end else if (fire) begin
      if (cw.shift) begin
        bits_q    <= bits_q >> 1;
        bit_cnt_q <= bit_cnt_q + 5'd1;
        gap_q     <= gap_q - (bits_q[0] ? BitOneTime : BitZeroTime);
      end
      if (cw.dec_rep) reps_q <= reps_q - 8'd1;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_valid_q <= 1'b0;
    end else if (fire) begin
      rsp_valid_q <= 1'b1;
    end else if (rsp_o.ready) begin
      rsp_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      mark_q   <= mark_val;
      space_q  <= space_val;
      last_q   <= done;
      status_q <= cw.status;
      dcnt_q   <= (done && !cw.status) ? count_q : '0;
    end
  end

  assign rsp_o.valid          = rsp_valid_q;
  assign rsp_o.mark_us        = mark_q;
  assign rsp_o.space_us       = space_q;
  assign rsp_o.last           = last_q;
  assign rsp_o.status         = status_q;
  assign rsp_o.duration_count = dcnt_q;

endmodule

// File: design/nec_enc_chk.sv
module nec_enc_chk (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_i,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [13:0] mark_us_i,
  input logic [16:0] space_us_i,
  input logic        last_i,
  input logic        status_i,
  input logic [8:0]  duration_count_i
);

  // a stalled result holds its payload
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(mark_us_i) &&
    $stable(space_us_i) && $stable(last_i) && $stable(duration_count_i))
    else $error("stalled result changed");

  // error result is a lone zero pair
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && status_i |-> last_i && mark_us_i == 14'd0 &&
    space_us_i == 17'd0 && duration_count_i == 9'd0)
    else $error("malformed error result");

  // count only on the closing pair
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !last_i |-> duration_count_i == 9'd0 && !status_i)
    else $error("count or status before last pair");

  // a good frame holds at least the main frame
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && last_i && !status_i |-> duration_count_i >= 9'd68)
    else $error("duration count too small");

  // a taken request keeps the block busy for the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> !in_ready_i)
    else $error("ready right after request");

endmodule

bind nec_ir_frame_encoder_top nec_enc_chk u_nec_enc_chk (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .in_valid_i       (req_i.valid),
  .in_ready_i       (req_i.ready),
  .out_valid_i      (rsp_o.valid),
  .out_ready_i      (rsp_o.ready),
  .mark_us_i        (rsp_o.mark_us),
  .space_us_i       (rsp_o.space_us),
  .last_i           (rsp_o.last),
  .status_i         (rsp_o.status),
  .duration_count_i (rsp_o.duration_count)
);

// File: verif/tb_nec_ir_frame_encoder_top.sv
module tb_nec_ir_frame_encoder_top;
  timeunit 1ns;
  timeprecision 1ps;

  import nec_enc_pkg::*;

  localparam int unsigned BufLen = BUFFER_LEN_DEF;

  // status codes carried on each result
  localparam logic StatusOk      = 1'b0;
  localparam logic StatusTooMany = 1'b1;

  typedef struct {
    logic [MarkW-1:0]  mark_us;
    logic [SpaceW-1:0] space_us;
    logic              last;
    logic              status;
    logic [CountW-1:0] duration_count;
  } ir_pair_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  nec_enc_req_if req_if ();
  nec_enc_rsp_if rsp_if ();

  nec_ir_frame_encoder_top #(
    .BUFFER_LEN (BufLen)
  ) uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if)
  );

  // pairs still owed by the block, oldest first
  ir_pair_t    pending_pairs_q[$];
  int unsigned error_count = 0;
  int unsigned sender_idle_pct = 23;
  int unsigned receiver_idle_pct = 45;

  always #10 clk_i = ~clk_i;

  // number of repeat frames that fit in the timing buffer
  function automatic int unsigned repeat_capacity();
    int unsigned n;
    int          idx;
    n   = 0;
    idx = 68;
    while (idx < int'(BufLen) - 4 && n < 255) begin
      idx += 4;
      n++;
    end
    return n;
  endfunction

  function automatic ir_pair_t make_pair(input int unsigned mark, input int unsigned space,
                                         input logic last, input logic status,
                                         input int unsigned count);
    ir_pair_t p;
    p.mark_us        = MarkW'(mark);
    p.space_us       = SpaceW'(space);
    p.last           = last;
    p.status         = status;
    p.duration_count = CountW'(count);
    return p;
  endfunction

  // queue up the mark/space pairs one request should produce
  function automatic void predict_frame(input logic [ByteW-1:0] addr,
                                        input logic [ByteW-1:0] cmd,
                                        input logic [ByteW-1:0] reps);
    logic [ByteW-1:0] frame_bytes [4];
    int unsigned      elapsed;
    int unsigned      durations;
    if (reps > repeat_capacity()) begin
      pending_pairs_q.push_back(make_pair(0, 0, 1'b1, StatusTooMany, 0));
      return;
    end
    frame_bytes[0] = addr;
    frame_bytes[1] = ~addr;
    frame_bytes[2] = cmd;
    frame_bytes[3] = ~cmd;
    durations = 68 + 4 * reps;
    elapsed   = 13500;
    pending_pairs_q.push_back(make_pair(9000, 4500, 1'b0, StatusOk, 0));
    for (int b = 0; b < 4; b++) begin
      for (int i = 0; i < 8; i++) begin
        if (frame_bytes[b][i]) begin
          pending_pairs_q.push_back(make_pair(560, 1690, 1'b0, StatusOk, 0));
          elapsed += 2250;
        end else begin
          pending_pairs_q.push_back(make_pair(560, 560, 1'b0, StatusOk, 0));
          elapsed += 1120;
        end
      end
    end
    elapsed += 560;
    // stop mark, padded out to the 110 ms frame period
    pending_pairs_q.push_back(make_pair(560, 110000 - elapsed, reps == 0, StatusOk,
                                        (reps == 0) ? durations : 0));
    for (int r = 0; r < int'(reps); r++) begin
      pending_pairs_q.push_back(make_pair(9000, 2250, 1'b0, StatusOk, 0));
      pending_pairs_q.push_back(make_pair(560, 98190, r == int'(reps) - 1, StatusOk,
                                          (r == int'(reps) - 1) ? durations : 0));
    end
  endfunction

  task automatic report_mismatch(input string field, input int unsigned got,
                                 input int unsigned want);
    $display("ERROR at %0t: %s is %0d, expected %0d", $time, field, got, want);
    error_count++;
  endtask

  // one request: optional idle cycles, then hold valid until taken
  task automatic send_request(input logic [ByteW-1:0] addr, input logic [ByteW-1:0] cmd,
                              input logic [ByteW-1:0] reps);
    while ($urandom_range(0, 99) < sender_idle_pct) begin
      req_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    req_if.valid        <= 1'b1;
    req_if.address      <= addr;
    req_if.command      <= cmd;
    req_if.repeat_count <= reps;
    do @(posedge clk_i); while (!req_if.ready);
    predict_frame(addr, cmd, reps);
  endtask

  // receiver back-pressure
  always @(posedge clk_i) begin
    rsp_if.ready <= ($urandom_range(0, 99) >= receiver_idle_pct);
  end

  // compare every taken result with the oldest pending pair
  always @(posedge clk_i) begin : check_result
    ir_pair_t want;
    if (rst_ni && rsp_if.valid && rsp_if.ready) begin
      if (pending_pairs_q.size() == 0) begin
        report_mismatch("unexpected result, mark_us", rsp_if.mark_us, 0);
      end else begin
        want = pending_pairs_q.pop_front();
        if (rsp_if.mark_us !== want.mark_us)
          report_mismatch("mark_us", rsp_if.mark_us, want.mark_us);
        if (rsp_if.space_us !== want.space_us)
          report_mismatch("space_us", rsp_if.space_us, want.space_us);
        if (rsp_if.last !== want.last)
          report_mismatch("last", rsp_if.last, want.last);
        if (rsp_if.status !== want.status)
          report_mismatch("status", rsp_if.status, want.status);
        if (rsp_if.duration_count !== want.duration_count)
          report_mismatch("duration_count", rsp_if.duration_count, want.duration_count);
      end
    end
  end

  // all-zero, all-one, mixed, alternating and single-bit address and command bytes
  task automatic test_field_extremes();
    send_request(8'h00, 8'h00, 8'd0);
    send_request(8'hFF, 8'hFF, 8'd0);
    send_request(8'h00, 8'hFF, 8'd0);
    send_request(8'hFF, 8'h00, 8'd0);
    send_request(8'hA5, 8'h5A, 8'd0);
    send_request(8'h5A, 8'hA5, 8'd0);
    send_request(8'h01, 8'h80, 8'd0);
    send_request(8'h80, 8'h01, 8'd0);
  endtask

  // repeat counts around the buffer limit, and far beyond it
  task automatic test_repeat_bounds();
    int unsigned cap;
    cap = repeat_capacity();
    send_request(8'h12, 8'h34, 8'd1);
    send_request(8'h56, 8'h78, 8'd2);
    send_request(8'h9A, 8'hBC, ByteW'(cap - 1));
    send_request(8'hDE, 8'hF0, ByteW'(cap));
    send_request(8'h0F, 8'hF0, ByteW'(cap + 1));
    send_request(8'hF0, 8'h0F, 8'h80);
    send_request(8'hFF, 8'hFF, 8'hFF);
    send_request(8'h00, 8'h00, 8'h7F);
    send_request(8'h3C, 8'hC3, 8'h55);
    send_request(8'hC3, 8'h3C, 8'hAA);
    send_request(8'h00, 8'hFF, ByteW'(cap));
    send_request(8'hFF, 8'h00, 8'd1);
  endtask

  // random frames, mostly within the repeat limit
  task automatic test_random_frames(input int unsigned snd_pct, input int unsigned rcv_pct,
                                    input int unsigned n_items);
    int unsigned      cap;
    int unsigned      pick;
    logic [ByteW-1:0] reps;
    cap               = repeat_capacity();
    sender_idle_pct   = snd_pct;
    receiver_idle_pct = rcv_pct;
    for (int n = 0; n < int'(n_items); n++) begin
      pick = $urandom_range(0, 99);
      if (pick < 70)
        reps = ByteW'($urandom_range(0, cap));
      else if (pick < 80)
        reps = ByteW'(cap);
      else
        reps = ByteW'($urandom_range(0, 255));
      send_request(ByteW'($urandom), ByteW'($urandom), reps);
    end
  endtask

  initial begin
    rst_ni              <= 1'b0;
    req_if.valid        <= 1'b0;
    req_if.address      <= '0;
    req_if.command      <= '0;
    req_if.repeat_count <= '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_field_extremes();
    test_repeat_bounds();
    test_random_frames(23, 45, 50);
    test_random_frames(45, 23, 50);
    test_random_frames(0, 0, 50);

    req_if.valid <= 1'b0;
    while (pending_pairs_q.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (error_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // watchdog
  initial begin
    #20_000_000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule
